@@ rtl/core/utdf_pkg.sv @@
// ----------------------------------------------------------------------------
// utdf_pkg
// Shared constants, types and state codes of the unordered tuple dedup filter.
// ----------------------------------------------------------------------------
package utdf_pkg;

   localparam int KeyLen        = 5;
   localparam int VertexBits    = 20;
   localparam int PositionBits  = 11;
   localparam int EpochBits     = 8;
   localparam int DefIndexBits  = 20;
   localparam int DefTableDepth = 1024;

   localparam int ReqDataBits = ((KeyLen * VertexBits + 7) / 8) * 8;
   localparam int RspDataBits = ((PositionBits + 7) / 8) * 8;
   localparam int RspUserBits = 2;

   localparam logic [31:0] MixMul = 32'h0100_0193;

   localparam logic [EpochBits-1:0] EpochFirst = EpochBits'(1);
   localparam logic [EpochBits-1:0] EpochLast  = '1;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_SORT,
      ST_READ,
      ST_CHECK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                    table_full;
      logic                    keep;
      logic [PositionBits-1:0] position;
   } result_type;

endpackage

@@ rtl/core/utdf_sorter.sv @@
// ----------------------------------------------------------------------------
// utdf_sorter
// Odd-even transposition sorter: one compare-exchange phase per cycle over
// the five indices, ascending from lane 0.
// ----------------------------------------------------------------------------
module utdf_sorter
   import utdf_pkg::*;
#(
   parameter int INDEX_BITS = DefIndexBits
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic [KeyLen-1:0][INDEX_BITS-1:0]  keys_in,
   output logic                               busy,
   output logic [KeyLen-1:0][INDEX_BITS-1:0]  keys_out
);

   localparam int PhaseBits = $clog2(KeyLen);
   localparam logic [PhaseBits-1:0] PhaseLast = PhaseBits'(KeyLen - 1);

   logic [KeyLen-1:0][INDEX_BITS-1:0] vals_ff, vals_in;
   logic [PhaseBits-1:0]              phase_ff, phase_in;
   logic                              busy_ff, busy_in;
   logic [KeyLen-1:0][INDEX_BITS-1:0] swapped;

   always_comb begin
      swapped = vals_ff;
      for (int i = 0; i < KeyLen - 1; i++) begin
         if ((1'(i) == phase_ff[0]) && (vals_ff[i] > vals_ff[i+1])) begin
            swapped[i]   = vals_ff[i+1];
            swapped[i+1] = vals_ff[i];
         end
      end
   end

   always_comb begin
      vals_in  = vals_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      if (load) begin
         vals_in  = keys_in;
         phase_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         vals_in  = swapped;
         phase_in = phase_ff + PhaseBits'(1);
         if (phase_ff == PhaseLast) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      vals_ff <= vals_in;
      if (reset) begin
         phase_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign keys_out = vals_ff;

endmodule

@@ rtl/core/utdf_hash.sv @@
// ----------------------------------------------------------------------------
// utdf_hash
// Order-free slot hash: each index is mixed by a multiply in its own lane,
// the lanes are summed, folded and reduced below the table depth.
// ----------------------------------------------------------------------------
module utdf_hash
   import utdf_pkg::*;
#(
   parameter int INDEX_BITS  = DefIndexBits,
   parameter int TABLE_DEPTH = DefTableDepth
) (
   input  logic                                     clock,
   input  logic                                     load,
   input  logic [KeyLen-1:0][INDEX_BITS-1:0]        keys_in,
   output logic [$clog2(TABLE_DEPTH)-1:0]           slot
);

   localparam int SlotBits = $clog2(TABLE_DEPTH);
   localparam logic [SlotBits:0] DepthWide = (SlotBits + 1)'(TABLE_DEPTH);

   logic [KeyLen-1:0][31:0] prod_ff, prod_in;
   logic [SlotBits-1:0]     slot_ff, slot_in;
   logic [31:0]             sum;
   logic [31:0]             mixed;
   logic [SlotBits:0]       folded;
   logic [SlotBits:0]       reduced;

   always_comb begin
      for (int i = 0; i < KeyLen; i++) begin
         prod_in[i] = load ? 32'(32'(keys_in[i]) * MixMul) : prod_ff[i];
      end
   end

   always_comb begin
      sum = '0;
      for (int i = 0; i < KeyLen; i++) begin
         sum = sum + prod_ff[i];
      end
      mixed   = sum ^ (sum >> 15);
      folded  = {1'b0, mixed[SlotBits-1:0]};
      reduced = (folded >= DepthWide) ? (folded - DepthWide) : folded;
      slot_in = reduced[SlotBits-1:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      slot_ff <= slot_in;
   end

   assign slot = slot_ff;

endmodule

@@ rtl/core/utdf_key_store.sv @@
// ----------------------------------------------------------------------------
// utdf_key_store
// Simple dual-port key memory: one write port, one read port with a
// registered read word.
// ----------------------------------------------------------------------------
module utdf_key_store
   import utdf_pkg::*;
#(
   parameter int DATA_BITS = EpochBits + KeyLen * DefIndexBits,
   parameter int DEPTH     = DefTableDepth
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [DATA_BITS-1:0]      rd_data,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [DATA_BITS-1:0]      wr_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/unordered_tuple_dedup_filter.sv @@
// ----------------------------------------------------------------------------
// unordered_tuple_dedup_filter
// Duplicate filter for five-index cells, keyed on the sorted index set.
// ----------------------------------------------------------------------------
// One word is handled at a time. A word passes the sort stage, then one read
// and one compare per probe of the key memory, then a step that hands the
// result to the output register once that register is free. A further probe
// of the linear chain adds a read and a compare, up to TABLE_DEPTH probes when
// the table is full. The next word is taken only after the last result has
// been handed on. Entries carry an 8-bit pass tag instead of valid bits; a
// start of pass advances the tag and clears the kept count. After reset, and
// on every 255th start of pass when the tag wraps, the block sweeps every
// entry of the key memory with req_tready low. A finished result waits in the
// output register while the next word is taken in.
// ----------------------------------------------------------------------------
module unordered_tuple_dedup_filter
   import utdf_pkg::*;
#(
   parameter int INDEX_BITS  = DefIndexBits,
   parameter int TABLE_DEPTH = DefTableDepth
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // vertex_a, vertex_b, vertex_c, vertex_d, vertex_e, zero pad
   input  logic [ReqDataBits-1:0]  req_tdata,
   // start_of_pass
   input  logic                    req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // position, zero pad
   output logic [RspDataBits-1:0]  rsp_tdata,
   // keep, table_full
   output logic [RspUserBits-1:0]  rsp_tuser
);

   localparam int SlotBits  = $clog2(TABLE_DEPTH);
   localparam int CountBits = $clog2(TABLE_DEPTH + 1);
   localparam int KeyBits   = KeyLen * INDEX_BITS;
   localparam int WordBits  = EpochBits + KeyBits;
   localparam logic [SlotBits-1:0]  SlotLast  = SlotBits'(TABLE_DEPTH - 1);
   localparam logic [CountBits-1:0] CountFull = CountBits'(TABLE_DEPTH);

   state_type               state_ff, state_in;
   logic [EpochBits-1:0]    epoch_ff, epoch_in;
   logic [CountBits-1:0]    count_ff, count_in;
   logic [CountBits-1:0]    probes_ff, probes_in;
   logic [SlotBits-1:0]     slot_ff, slot_in;
   logic [SlotBits-1:0]     sweep_addr_ff, sweep_addr_in;
   logic                    resume_ff, resume_in;
   result_type              res_ff, res_in;
   result_type              rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [KeyLen-1:0][INDEX_BITS-1:0] vertices;
   logic [KeyLen-1:0][INDEX_BITS-1:0] sorted;
   logic [KeyBits-1:0]                sorted_flat;
   logic                              sort_busy;
   logic [SlotBits-1:0]               hash_slot;
   logic                              req_accept;

   logic                  mem_rd_en;
   logic [WordBits-1:0]   mem_rd_data;
   logic                  mem_wr_en;
   logic [SlotBits-1:0]   mem_wr_addr;
   logic [WordBits-1:0]   mem_wr_data;
   logic [EpochBits-1:0]  entry_tag;
   logic [KeyBits-1:0]    entry_key;

   always_comb begin
      for (int i = 0; i < KeyLen; i++) begin
         vertices[i] = INDEX_BITS'(req_tdata[i*VertexBits +: VertexBits]);
      end
   end

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign sorted_flat = sorted;
   assign entry_tag   = mem_rd_data[WordBits-1 -: EpochBits];
   assign entry_key   = mem_rd_data[KeyBits-1:0];

   utdf_sorter #(
      .INDEX_BITS (INDEX_BITS)
   ) u_sorter (
      .clock    (clock),
      .reset    (reset),
      .load     (req_accept),
      .keys_in  (vertices),
      .busy     (sort_busy),
      .keys_out (sorted)
   );

   utdf_hash #(
      .INDEX_BITS  (INDEX_BITS),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_hash (
      .clock   (clock),
      .load    (req_accept),
      .keys_in (vertices),
      .slot    (hash_slot)
   );

   utdf_key_store #(
      .DATA_BITS (WordBits),
      .DEPTH     (TABLE_DEPTH)
   ) u_key_store (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (slot_ff),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   always_comb begin
      state_in      = state_ff;
      epoch_in      = epoch_ff;
      count_in      = count_ff;
      probes_in     = probes_ff;
      slot_in       = slot_ff;
      sweep_addr_in = sweep_addr_ff;
      resume_in     = resume_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      mem_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = slot_ff;
      mem_wr_data   = {epoch_ff, sorted_flat};

      unique case (state_ff)
         ST_SWEEP: begin
            mem_wr_en     = 1'b1;
            mem_wr_addr   = sweep_addr_ff;
            mem_wr_data   = '0;
            sweep_addr_in = sweep_addr_ff + SlotBits'(1);
            if (sweep_addr_ff == SlotLast) begin
               sweep_addr_in = '0;
               resume_in     = 1'b0;
               state_in      = resume_ff ? ST_SORT : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SORT;
               if (req_tuser) begin
                  count_in = '0;
                  if (epoch_ff == EpochLast) begin
                     epoch_in      = EpochFirst;
                     resume_in     = 1'b1;
                     sweep_addr_in = '0;
                     state_in      = ST_SWEEP;
                  end else begin
                     epoch_in = epoch_ff + EpochBits'(1);
                  end
               end
            end
         end
         ST_SORT: begin
            if (!sort_busy) begin
               slot_in   = hash_slot;
               probes_in = '0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            mem_rd_en = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            res_in.position   = PositionBits'(count_ff);
            res_in.table_full = 1'b0;
            if (entry_tag != epoch_ff) begin
               mem_wr_en   = 1'b1;
               res_in.keep = 1'b1;
               count_in    = count_ff + CountBits'(1);
               state_in    = ST_EMIT;
            end else if (entry_key == sorted_flat) begin
               res_in.keep = 1'b0;
               state_in    = ST_EMIT;
            end else begin
               probes_in = probes_ff + CountBits'(1);
               slot_in   = (slot_ff == SlotLast) ? '0 : slot_ff + SlotBits'(1);
               if (probes_in == CountFull) begin
                  res_in.keep       = 1'b1;
                  res_in.table_full = 1'b1;
                  state_in          = ST_EMIT;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      probes_ff <= probes_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff      <= ST_SWEEP;
         epoch_ff      <= EpochFirst;
         count_ff      <= '0;
         sweep_addr_ff <= '0;
         resume_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         epoch_ff      <= epoch_in;
         count_ff      <= count_in;
         sweep_addr_ff <= sweep_addr_in;
         resume_ff     <= resume_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspDataBits'(rsp_ff.position);
   assign rsp_tuser  = {rsp_ff.table_full, rsp_ff.keep};

endmodule

@@ rtl/core/utdf_checker.sv @@
// ----------------------------------------------------------------------------
// utdf_checker
// Port-level checks of the unordered tuple dedup filter, bound to the top.
// ----------------------------------------------------------------------------
module utdf_checker
   import utdf_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataBits-1:0]  rsp_tdata,
   input logic [RspUserBits-1:0]  rsp_tuser
);

   // hold a stalled result word
   rsp_hold_check: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // full flag only on kept words
   full_keep_check: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("table_full without keep");

   // one word in flight: no accept right after an accept
   one_word_check: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken twice in a row");

   // reset drops result and input readiness
   reset_check: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("ports active after reset");

endmodule

bind unordered_tuple_dedup_filter utdf_checker u_checker (.*);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the unordered tuple dedup filter.
// ----------------------------------------------------------------------------
// Cells of five vertex indices are driven on the request stream. A
// scoreboard keeps the set of sorted keys seen in the current pass and the
// kept count, and works out the verdict (keep, position, table full) for
// every accepted word. Each response word is checked against the oldest
// pending verdict. Stimulus has a directed part, then random passes with
// repeats in shuffled order, near misses and stray pass starts, one pass that
// overfills the table, tiny passes that wrap the pass tag, then more random
// passes. Both streams stall at random, except during the overfill pass.
// ----------------------------------------------------------------------------
module tb_top;
   import utdf_pkg::*;

   localparam int CellBits   = KeyLen * VertexBits;
   localparam int StallLimit = 20000;
   localparam int DrainWait  = 64;

   class verdict_scoreboard;
      bit          seen_keys [logic [CellBits-1:0]];
      int unsigned kept_count;
      int unsigned table_depth;
      int unsigned error_count;
      result_type  verdict_q [$];

      function new(int unsigned depth);
         table_depth = depth;
         kept_count  = 0;
         error_count = 0;
      endfunction

      function void note_cell(bit start, logic [ReqDataBits-1:0] req_word);
         logic [VertexBits-1:0] vtx [KeyLen];
         logic [VertexBits-1:0] tmp;
         logic [CellBits-1:0]   key;
         result_type            want;
         if (start) begin
            seen_keys.delete();
            kept_count = 0;
         end
         for (int i = 0; i < KeyLen; i++) vtx[i] = req_word[i*VertexBits +: VertexBits];
         for (int i = 0; i < KeyLen - 1; i++) begin
            for (int j = 0; j < KeyLen - 1 - i; j++) begin
               if (vtx[j] > vtx[j+1]) begin
                  tmp      = vtx[j];
                  vtx[j]   = vtx[j+1];
                  vtx[j+1] = tmp;
               end
            end
         end
         for (int i = 0; i < KeyLen; i++) key[i*VertexBits +: VertexBits] = vtx[i];
         want.position   = PositionBits'(kept_count);
         want.keep       = !seen_keys.exists(key);
         want.table_full = 1'b0;
         if (want.keep) begin
            if (kept_count < table_depth) begin
               seen_keys[key] = 1'b1;
               kept_count++;
            end else begin
               want.table_full = 1'b1;
            end
         end
         verdict_q.push_back(want);
      endfunction

      function void check_verdict(logic keep, logic table_full,
                                  logic [PositionBits-1:0] position);
         result_type want;
         if (verdict_q.size() == 0) begin
            $error("unexpected response word: keep %0d table_full %0d position %0d",
                   keep, table_full, position);
            error_count++;
            return;
         end
         want = verdict_q.pop_front();
         if (keep !== want.keep) begin
            $error("keep: expected %0d, actual %0d", want.keep, keep);
            error_count++;
         end
         if (table_full !== want.table_full) begin
            $error("table_full: expected %0d, actual %0d", want.table_full, table_full);
            error_count++;
         end
         if (position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, position);
            error_count++;
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ReqDataBits-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspDataBits-1:0] rsp_tdata;
   logic [RspUserBits-1:0] rsp_tuser;

   verdict_scoreboard board;
   bit                no_idle      = 1'b0;
   int unsigned       stall_cycles = 0;

   unordered_tuple_dedup_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= 30);
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_verdict(rsp_tuser[0], rsp_tuser[1], rsp_tdata[PositionBits-1:0]);
      end
   end

   always @(negedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= StallLimit) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   function automatic logic [ReqDataBits-1:0] cell_of(logic [VertexBits-1:0] a,
      logic [VertexBits-1:0] b, logic [VertexBits-1:0] c, logic [VertexBits-1:0] d,
      logic [VertexBits-1:0] e);
      return ReqDataBits'({e, d, c, b, a});
   endfunction

   function automatic logic [VertexBits-1:0] random_vertex();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) return '0;
      if (pick < 20) return '1;
      if (pick < 35) return VertexBits'($urandom_range(7));
      return VertexBits'($urandom);
   endfunction

   function automatic logic [ReqDataBits-1:0] random_cell(bit wide_only);
      logic [ReqDataBits-1:0] req_word;
      req_word = '0;
      for (int i = 0; i < KeyLen; i++) begin
         req_word[i*VertexBits +: VertexBits] = wide_only ? VertexBits'($urandom) :
                                                            random_vertex();
      end
      return req_word;
   endfunction

   function automatic logic [ReqDataBits-1:0] shuffle_cell(logic [ReqDataBits-1:0] req_word);
      logic [VertexBits-1:0] tmp;
      int unsigned           i;
      int unsigned           j;
      for (int n = 0; n < 6; n++) begin
         i = $urandom_range(KeyLen - 1);
         j = $urandom_range(KeyLen - 1);
         tmp = req_word[i*VertexBits +: VertexBits];
         req_word[i*VertexBits +: VertexBits] = req_word[j*VertexBits +: VertexBits];
         req_word[j*VertexBits +: VertexBits] = tmp;
      end
      return req_word;
   endfunction

   task automatic send_cell(bit start, logic [ReqDataBits-1:0] req_word);
      while (!no_idle && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= start;
      req_tdata  <= req_word;
      do @(negedge clock); while (!req_tready);
      board.note_cell(start, req_word);
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.verdict_q.size() != 0) @(posedge clock);
   endtask

   task automatic run_pass(int unsigned len);
      logic [ReqDataBits-1:0] pass_cells [$];
      logic [ReqDataBits-1:0] req_word;
      int unsigned            pick;
      bit                     start;
      for (int unsigned n = 0; n < len; n++) begin
         pick  = $urandom_range(99);
         start = (n == 0) || ($urandom_range(99) < 3);
         if (pass_cells.size() != 0 && pick < 40) begin
            req_word = shuffle_cell(pass_cells[$urandom_range(pass_cells.size() - 1)]);
         end else if (pass_cells.size() != 0 && pick < 50) begin
            req_word = pass_cells[$urandom_range(pass_cells.size() - 1)];
            req_word[$urandom_range(CellBits - 1)] ^= 1'b1;
         end else begin
            req_word = random_cell(1'b0);
         end
         pass_cells.push_back(req_word);
         send_cell(start, req_word);
      end
   endtask

   task automatic run_overfill();
      logic [ReqDataBits-1:0] fill_cells [$];
      logic [ReqDataBits-1:0] req_word;
      for (int n = 0; n < DefTableDepth + 8; n++) begin
         req_word = random_cell(1'b1);
         fill_cells.push_back(req_word);
         send_cell(n == 0, req_word);
      end
      for (int n = 0; n < 24; n++) begin
         if ($urandom_range(1) == 0) begin
            req_word = shuffle_cell(fill_cells[$urandom_range(fill_cells.size() - 1)]);
         end else begin
            req_word = random_cell(1'b1);
         end
         send_cell(1'b0, req_word);
      end
   endtask

   task automatic run_tiny_passes(int unsigned count);
      logic [ReqDataBits-1:0] pool [3];
      pool[0] = cell_of(20'h00001, 20'h00002, 20'h00003, 20'h00004, 20'h00005);
      pool[1] = cell_of(20'hFFFFF, 20'h00000, 20'hFFFFF, 20'h00000, 20'h7FFFF);
      pool[2] = random_cell(1'b1);
      for (int unsigned p = 0; p < count; p++) begin
         send_cell(1'b1, shuffle_cell(pool[$urandom_range(2)]));
         if ($urandom_range(1) == 1) send_cell(1'b0, shuffle_cell(pool[$urandom_range(2)]));
      end
   endtask

   initial begin
      int unsigned sent;
      int unsigned len;
      board = new(DefTableDepth);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_cell(1'b0, cell_of(20'h00000, 20'h00000, 20'h00000, 20'h00000, 20'h00000));
      send_cell(1'b0, cell_of(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF));
      send_cell(1'b0, cell_of(20'h00000, 20'h00000, 20'h00000, 20'h00000, 20'h00000));
      send_cell(1'b0, cell_of(20'h00001, 20'h00002, 20'h00003, 20'h00004, 20'h00005));
      send_cell(1'b0, cell_of(20'h00005, 20'h00004, 20'h00003, 20'h00002, 20'h00001));
      send_cell(1'b0, cell_of(20'h00003, 20'h00001, 20'h00005, 20'h00002, 20'h00004));
      send_cell(1'b0, cell_of(20'h00001, 20'h00002, 20'h00003, 20'h00004, 20'h00006));
      send_cell(1'b0, cell_of(20'h00001, 20'h00001, 20'h00002, 20'h00003, 20'h00004));
      send_cell(1'b0, cell_of(20'h00001, 20'h00002, 20'h00002, 20'h00003, 20'h00004));
      send_cell(1'b0, cell_of(20'h00004, 20'h00003, 20'h00002, 20'h00001, 20'h00001));
      send_cell(1'b0, cell_of(20'hFFFFF, 20'h00000, 20'hFFFFF, 20'h00000, 20'hFFFFF));
      send_cell(1'b0, cell_of(20'h00000, 20'hFFFFF, 20'h00000, 20'hFFFFF, 20'hFFFFF));
      send_cell(1'b1, cell_of(20'h00000, 20'h00000, 20'h00000, 20'h00000, 20'h00000));
      send_cell(1'b1, cell_of(20'h00000, 20'h00000, 20'h00000, 20'h00000, 20'h00000));
      send_cell(1'b0, cell_of(20'h00000, 20'h00000, 20'h00000, 20'h00000, 20'h00000));
      send_cell(1'b0, cell_of(20'h00001, 20'h00002, 20'h00003, 20'h00004, 20'h00005));
      send_cell(1'b0, cell_of(20'hAAAAA, 20'h55555, 20'hAAAAA, 20'h55555, 20'h12345));
      send_cell(1'b0, cell_of(20'h55555, 20'h55555, 20'hAAAAA, 20'h12345, 20'hAAAAA));
      send_cell(1'b0, cell_of(20'hEDCBA, 20'h80000, 20'h00001, 20'h7FFFF, 20'hFFFFE));
      send_cell(1'b1, cell_of(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF));
      send_cell(1'b0, cell_of(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFE));

      sent = 0;
      while (sent < 160) begin
         len = $urandom_range(5, 60);
         run_pass(len);
         sent += len;
      end

      // hold the sender until every verdict is back, then overfill with no stalls
      wait_drained();
      no_idle = 1'b1;
      run_overfill();
      no_idle = 1'b0;

      run_tiny_passes(260);

      sent = 0;
      while (sent < 120) begin
         len = $urandom_range(5, 60);
         run_pass(len);
         sent += len;
      end

      wait_drained();
      repeat (DrainWait) @(posedge clock);
      if (board.error_count == 0 && board.verdict_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
